FILE: hdl/ataseq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ATA PIO LBA28 sector sequencer.
// Used by ataseq_csr, ataseq_core and the top level; depends on nothing.
package ataseq_pkg;

   // Sector geometry and settle delay
   localparam int WORDS_PER_SECTOR = 256;
   localparam int SETTLE_READS     = 4;

   // Widths of the internal counters and port addresses
   localparam int POLL_W   = 20;
   localparam int SETTLE_W = 3;
   localparam int WORD_W   = 8;
   localparam int PORT_W   = 10;

   // Task file port addresses
   localparam logic [PORT_W-1:0] PRI_BASE_PORT = 10'h1F0;
   localparam logic [PORT_W-1:0] PRI_CTRL_PORT = 10'h3F6;
   localparam logic [PORT_W-1:0] SEC_BASE_PORT = 10'h170;
   localparam logic [PORT_W-1:0] SEC_CTRL_PORT = 10'h376;

   // Register offsets from the base port
   localparam logic [PORT_W-1:0] OFS_DATA    = 10'd0;
   localparam logic [PORT_W-1:0] OFS_COUNT   = 10'd2;
   localparam logic [PORT_W-1:0] OFS_LBA_LO  = 10'd3;
   localparam logic [PORT_W-1:0] OFS_LBA_MID = 10'd4;
   localparam logic [PORT_W-1:0] OFS_LBA_HI  = 10'd5;
   localparam logic [PORT_W-1:0] OFS_DEVSEL  = 10'd6;
   localparam logic [PORT_W-1:0] OFS_CMD     = 10'd7;

   // Command and device select bytes
   localparam logic [7:0] CMD_READ_PIO  = 8'h20;
   localparam logic [7:0] CMD_WRITE_PIO = 8'h30;
   localparam logic [7:0] CMD_FLUSH     = 8'hE7;
   localparam logic [7:0] DEVSEL_LBA    = 8'hE0;

   // Status register bit positions
   localparam int ST_BSY_BIT = 7;
   localparam int ST_DRQ_BIT = 3;
   localparam int ST_ERR_BIT = 0;

   // Request kinds
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_DONE  = 2'd2;
   localparam logic [1:0] REQ_HOSTW = 2'd3;

   // Completion status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT    = 2'd1;
   localparam logic [1:0] STATUS_DEV_ERR    = 2'd2;
   localparam logic [1:0] STATUS_ZERO_COUNT = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHANNEL    = 2'd0;
   localparam logic [1:0] CSR_DRIVE      = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT = 2'd2;

   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 20'd100000;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RDY_CMD, PH_SEL, PH_SETTLE_SEL, PH_CNT, PH_LBA0, PH_LBA1,
      PH_LBA2, PH_CMD, PH_DRQ, PH_DATA, PH_HOSTW, PH_SETTLE_SEC, PH_RDY_SEC,
      PH_FLUSH, PH_RDY_FLUSH
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [27:0] lba;
      logic [7:0]  sector_count;
      logic [15:0] data_word;
   } req_data_type;

   typedef struct packed {
      logic              bus_valid;
      logic              bus_write;
      logic [PORT_W-1:0] bus_port;
      logic              bus_wide;
      logic [15:0]       bus_data;
      logic              host_word_valid;
      logic [15:0]       host_word;
      logic              host_word_request;
      logic              done_res;
      logic [1:0]        status_code;
   } rsp_data_type;

   typedef struct packed {
      logic              channel_secondary;
      logic              drive_slave;
      logic [POLL_W-1:0] poll_limit;
   } cfg_type;

endpackage

FILE: hdl/ataseq_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the sector sequencer.
// Depends on ataseq_pkg for the register indexes and cfg_type.
module ataseq_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output ataseq_pkg::cfg_type cfg
);
   import ataseq_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] csr_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_CHANNEL:    cfg_in.channel_secondary = pwdata[0];
            CSR_DRIVE:      cfg_in.drive_slave       = pwdata[0];
            CSR_POLL_LIMIT: cfg_in.poll_limit        = pwdata[POLL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_secondary <= 1'b0;
         cfg_ff.drive_slave       <= 1'b0;
         cfg_ff.poll_limit        <= POLL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         CSR_CHANNEL:    prdata = {31'd0, cfg_ff.channel_secondary};
         CSR_DRIVE:      prdata = {31'd0, cfg_ff.drive_slave};
         CSR_POLL_LIMIT: prdata = {{(32-POLL_W){1'b0}}, cfg_ff.poll_limit};
         default:        prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/ataseq_core.sv
`timescale 1ns / 1ps
// Command state and single-pass step logic of the sector sequencer.
// Depends on ataseq_pkg for the phase enum, payload structs and constants.
module ataseq_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  ataseq_pkg::req_data_type item,
   input  ataseq_pkg::cfg_type      cfg,
   output ataseq_pkg::rsp_data_type step_rsp
);
   import ataseq_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [POLL_W-1:0]   poll_count_ff, poll_count_in;
   logic [WORD_W-1:0]   sectors_left_ff, sectors_left_in;
   logic [WORD_W-1:0]   word_index_ff, word_index_in;
   logic [27:0]         held_lba_ff, held_lba_in;
   logic [7:0]          held_count_ff, held_count_in;
   logic                is_write_ff, is_write_in;
   logic [SETTLE_W-1:0] settle_count_ff, settle_count_in;

   logic [PORT_W-1:0]   base_port;
   logic [PORT_W-1:0]   ctrl_port;
   logic [7:0]          status;
   logic                st_bsy, st_drq, st_err;
   logic                poll_spent;
   logic                settle_done;
   logic                last_word;
   logic [7:0]          devsel_byte;

   function automatic rsp_data_type bus_access(input logic wr,
                                               input logic [PORT_W-1:0] port,
                                               input logic wide,
                                               input logic [15:0] data);
      rsp_data_type r;
      r           = '0;
      r.bus_valid = 1'b1;
      r.bus_write = wr;
      r.bus_port  = port;
      r.bus_wide  = wide;
      r.bus_data  = data;
      return r;
   endfunction

   function automatic rsp_data_type finish_with(input logic [1:0] code);
      rsp_data_type r;
      r             = '0;
      r.done_res    = 1'b1;
      r.status_code = code;
      return r;
   endfunction

   // Port selection, status decode and counter limits
   assign base_port   = cfg.channel_secondary ? SEC_BASE_PORT : PRI_BASE_PORT;
   assign ctrl_port   = cfg.channel_secondary ? SEC_CTRL_PORT : PRI_CTRL_PORT;
   assign status      = item.data_word[7:0];
   assign st_bsy      = status[ST_BSY_BIT];
   assign st_drq      = status[ST_DRQ_BIT];
   assign st_err      = status[ST_ERR_BIT];
   assign poll_spent  = (poll_count_ff >= cfg.poll_limit);
   assign settle_done = (settle_count_ff >= SETTLE_W'(SETTLE_READS));
   assign last_word   = (word_index_ff == WORD_W'(WORDS_PER_SECTOR - 1));
   assign devsel_byte = DEVSEL_LBA | {3'd0, cfg.drive_slave, held_lba_ff[27:24]};

   // Next state
   always_comb begin
      phase_in        = phase_ff;
      poll_count_in   = poll_count_ff;
      sectors_left_in = sectors_left_ff;
      word_index_in   = word_index_ff;
      held_lba_in     = held_lba_ff;
      held_count_in   = held_count_ff;
      is_write_in     = is_write_ff;
      settle_count_in = settle_count_ff;
      if (fire) begin
         case (item.req_type)
            REQ_READ, REQ_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  held_lba_in   = item.lba;
                  held_count_in = item.sector_count;
                  is_write_in   = item.req_type[0];
                  word_index_in = '0;
                  if (item.sector_count != 8'd0) begin
                     sectors_left_in = item.sector_count;
                     phase_in        = PH_RDY_CMD;
                     poll_count_in   = POLL_W'(1);
                  end
               end
            end
            REQ_DONE: begin
               case (phase_ff)
                  PH_RDY_CMD: begin
                     if (!st_bsy) phase_in = PH_SEL;
                     else if (poll_spent) phase_in = PH_IDLE;
                     else poll_count_in = poll_count_ff + POLL_W'(1);
                  end
                  PH_SEL: begin
                     phase_in        = PH_SETTLE_SEL;
                     settle_count_in = SETTLE_W'(1);
                  end
                  PH_CNT:  phase_in = PH_LBA0;
                  PH_LBA0: phase_in = PH_LBA1;
                  PH_LBA1: phase_in = PH_LBA2;
                  PH_LBA2: phase_in = PH_CMD;
                  PH_CMD: begin
                     phase_in      = PH_DRQ;
                     poll_count_in = POLL_W'(1);
                  end
                  PH_DRQ: begin
                     if (st_err) begin
                        phase_in = PH_IDLE;
                     end else if (!st_bsy && st_drq) begin
                        phase_in      = is_write_ff ? PH_HOSTW : PH_DATA;
                        word_index_in = '0;
                     end else if (poll_spent) begin
                        phase_in = PH_IDLE;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_DATA: begin
                     if (last_word) begin
                        word_index_in   = '0;
                        sectors_left_in = sectors_left_ff - WORD_W'(1);
                        phase_in        = PH_SETTLE_SEC;
                        settle_count_in = SETTLE_W'(1);
                     end else begin
                        word_index_in = word_index_ff + WORD_W'(1);
                        if (is_write_ff) phase_in = PH_HOSTW;
                     end
                  end
                  PH_SETTLE_SEL, PH_SETTLE_SEC: begin
                     if (!settle_done) begin
                        settle_count_in = settle_count_ff + SETTLE_W'(1);
                     end else if (phase_ff == PH_SETTLE_SEL) begin
                        phase_in = PH_CNT;
                     end else if (is_write_ff) begin
                        phase_in      = PH_RDY_SEC;
                        poll_count_in = POLL_W'(1);
                     end else if (sectors_left_ff != '0) begin
                        phase_in      = PH_DRQ;
                        poll_count_in = POLL_W'(1);
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_RDY_SEC: begin
                     if (!st_bsy) begin
                        if (sectors_left_ff != '0) begin
                           phase_in      = PH_DRQ;
                           poll_count_in = POLL_W'(1);
                        end else begin
                           phase_in = PH_FLUSH;
                        end
                     end else if (poll_spent) begin
                        phase_in = PH_IDLE;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_FLUSH: begin
                     phase_in      = PH_RDY_FLUSH;
                     poll_count_in = POLL_W'(1);
                  end
                  PH_RDY_FLUSH: begin
                     if (!st_bsy || poll_spent) phase_in = PH_IDLE;
                     else poll_count_in = poll_count_ff + POLL_W'(1);
                  end
                  default: phase_in = phase_ff;
               endcase
            end
            REQ_HOSTW: begin
               if (phase_ff == PH_HOSTW) phase_in = PH_DATA;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result of the step
   always_comb begin
      step_rsp = '0;
      case (item.req_type)
         REQ_READ, REQ_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               if (item.sector_count == 8'd0) step_rsp = finish_with(STATUS_ZERO_COUNT);
               else step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
            end
         end
         REQ_DONE: begin
            case (phase_ff)
               PH_RDY_CMD: begin
                  if (!st_bsy)
                     step_rsp = bus_access(1'b1, base_port + OFS_DEVSEL, 1'b0,
                                           {8'd0, devsel_byte});
                  else if (poll_spent) step_rsp = finish_with(STATUS_TIMEOUT);
                  else step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
               end
               PH_SEL: step_rsp = bus_access(1'b0, ctrl_port, 1'b0, 16'd0);
               PH_CNT:
                  step_rsp = bus_access(1'b1, base_port + OFS_LBA_LO, 1'b0,
                                        {8'd0, held_lba_ff[7:0]});
               PH_LBA0:
                  step_rsp = bus_access(1'b1, base_port + OFS_LBA_MID, 1'b0,
                                        {8'd0, held_lba_ff[15:8]});
               PH_LBA1:
                  step_rsp = bus_access(1'b1, base_port + OFS_LBA_HI, 1'b0,
                                        {8'd0, held_lba_ff[23:16]});
               PH_LBA2:
                  step_rsp = bus_access(1'b1, base_port + OFS_CMD, 1'b0,
                                        {8'd0, is_write_ff ? CMD_WRITE_PIO : CMD_READ_PIO});
               PH_CMD: step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
               PH_DRQ: begin
                  if (st_err) begin
                     step_rsp = finish_with(STATUS_DEV_ERR);
                  end else if (!st_bsy && st_drq) begin
                     if (is_write_ff) step_rsp.host_word_request = 1'b1;
                     else step_rsp = bus_access(1'b0, base_port + OFS_DATA, 1'b1, 16'd0);
                  end else if (poll_spent) begin
                     step_rsp = finish_with(STATUS_TIMEOUT);
                  end else begin
                     step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
                  end
               end
               PH_DATA: begin
                  if (last_word) begin
                     step_rsp = bus_access(1'b0, ctrl_port, 1'b0, 16'd0);
                  end else if (is_write_ff) begin
                     step_rsp.host_word_request = 1'b1;
                  end else begin
                     step_rsp = bus_access(1'b0, base_port + OFS_DATA, 1'b1, 16'd0);
                  end
                  // Hand the word just read to the host
                  if (!is_write_ff) begin
                     step_rsp.host_word_valid = 1'b1;
                     step_rsp.host_word       = item.data_word;
                  end
               end
               PH_SETTLE_SEL, PH_SETTLE_SEC: begin
                  if (!settle_done)
                     step_rsp = bus_access(1'b0, ctrl_port, 1'b0, 16'd0);
                  else if (phase_ff == PH_SETTLE_SEL)
                     step_rsp = bus_access(1'b1, base_port + OFS_COUNT, 1'b0,
                                           {8'd0, held_count_ff});
                  else if (is_write_ff || sectors_left_ff != '0)
                     step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
                  else
                     step_rsp = finish_with(STATUS_OK);
               end
               PH_RDY_SEC: begin
                  if (!st_bsy) begin
                     if (sectors_left_ff != '0)
                        step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
                     else
                        step_rsp = bus_access(1'b1, base_port + OFS_CMD, 1'b0,
                                              {8'd0, CMD_FLUSH});
                  end else if (poll_spent) begin
                     step_rsp = finish_with(STATUS_TIMEOUT);
                  end else begin
                     step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
                  end
               end
               PH_FLUSH: step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
               PH_RDY_FLUSH: begin
                  // A flush that never finishes still ends the command cleanly
                  if (!st_bsy || poll_spent) step_rsp = finish_with(STATUS_OK);
                  else step_rsp = bus_access(1'b0, base_port + OFS_CMD, 1'b0, 16'd0);
               end
               default: step_rsp = '0;
            endcase
         end
         REQ_HOSTW: begin
            if (phase_ff == PH_HOSTW)
               step_rsp = bus_access(1'b1, base_port + OFS_DATA, 1'b1, item.data_word);
         end
         default: step_rsp = '0;
      endcase
   end

   // Hold or advance the command state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         poll_count_ff   <= '0;
         sectors_left_ff <= '0;
         word_index_ff   <= '0;
         held_lba_ff     <= '0;
         held_count_ff   <= '0;
         is_write_ff     <= 1'b0;
         settle_count_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         poll_count_ff   <= poll_count_in;
         sectors_left_ff <= sectors_left_in;
         word_index_ff   <= word_index_in;
         held_lba_ff     <= held_lba_in;
         held_count_ff   <= held_count_in;
         is_write_ff     <= is_write_in;
         settle_count_ff <= settle_count_in;
      end
   end

   // A finished command leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      fire && step_rsp.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after command end");

   // An access, a word request and a completion never share one result
   assert property (@(posedge clock) disable iff (reset)
      fire |-> $onehot0({step_rsp.bus_valid, step_rsp.host_word_request,
                         step_rsp.done_res}))
      else $error("conflicting actions in one result");

   // The word index only moves inside a sector transfer
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA && phase_ff != PH_HOSTW) |-> word_index_ff == '0)
      else $error("word index left nonzero outside data transfer");

   // Sector words go to the host on read commands only
   assert property (@(posedge clock) disable iff (reset)
      fire && step_rsp.host_word_valid |-> !is_write_ff && phase_ff == PH_DATA)
      else $error("host word delivered outside a read transfer");

endmodule

FILE: hdl/ata_pio_lba28_sector_sequencer.sv
`timescale 1ns / 1ps
// ATA PIO LBA28 sector sequencer top level: request and result registers
// around ataseq_core, plus the ataseq_csr configuration registers; uses ataseq_pkg.
//
// Every accepted request (start read, start write, bus completion, host write
// word) yields exactly one result: it is held in the request register, then
// passes through the step logic into the result register. A new request is
// accepted every cycle while results are taken as they appear.
// While a stalled result waits, one more request is taken into the request
// register, and req_stall then stays high until the result leaves. The command
// state lives in ataseq_core and is updated in the same cycle that a request
// passes through the step logic, which sets the one-per-cycle rate.
// The sequencer issues at most one port access per result and expects the bus
// completion as a later request. The user must write configuration only while
// no command is running; the block itself does not enforce it.
module ata_pio_lba28_sector_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ataseq_pkg::req_data_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ataseq_pkg::rsp_data_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import ataseq_pkg::*;

   logic         req_valid_ff;
   req_data_type req_ff;
   logic         rsp_valid_ff;
   rsp_data_type rsp_ff;
   logic         advance;
   cfg_type      cfg;
   rsp_data_type step_rsp;

   ataseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ataseq_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (req_ff),
      .cfg      (cfg),
      .step_rsp (step_rsp)
   );

   // Move the held request through when the result register can take it
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
